[rtl/core/gll_pkg.sv]
// Shared types, constants and saturation helpers for the glyph line layout core.
// Depends on nothing; every other file of the block refers to it by scoped names.
package gll_pkg;

  // Item kinds carried in the mode field.
  typedef enum logic [1:0] {
    MODE_START = 2'd0,
    MODE_TEXT  = 2'd1,
    MODE_LOAD  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_FONT_IS_SANS  = 2'd0,
    CFG_TEXT_SIZE     = 2'd1,
    CFG_ADVANCE_SCALE = 2'd2,
    CFG_WRAP_WIDTH    = 2'd3
  } cfg_reg_e;

  localparam int unsigned GLYPH_SLOTS_DEF = 128;
  localparam int unsigned CFG_IDX_W       = 2;

  // Field widths.
  localparam int unsigned POS_W   = 24;
  localparam int unsigned SIZE_W  = 16;
  localparam int unsigned ADV_W   = 16;
  localparam int unsigned SCALE_W = 16;
  localparam int unsigned CP_W    = 7;
  localparam int unsigned COLOR_W = 32;
  // Scaled advance: Q8.8 times Q4.12 gives Q.20, shifted down to Q.6.
  localparam int unsigned ADV_SHIFT = 14;
  localparam int unsigned SADV_W    = ADV_W + SCALE_W - ADV_SHIFT;

  // Character codes.
  localparam logic [CP_W-1:0] CP_FIRST    = 7'd32;
  localparam logic [CP_W-1:0] CP_LAST     = 7'd126;
  localparam logic [CP_W-1:0] CP_NEWLINE  = 7'h0A;
  localparam logic [CP_W-1:0] CP_QUESTION = 7'h3F;

  localparam logic [POS_W-1:0] UMAX24 = 24'hFF_FFFF;
  localparam logic signed [POS_W-1:0] SMAX24 = 24'sh7F_FFFF;
  localparam logic signed [POS_W-1:0] SMIN24 = 24'sh80_0000;

  // Configuration register file contents.
  typedef struct packed {
    logic               font_is_sans;
    logic [SIZE_W-1:0]  text_size;
    logic [SCALE_W-1:0] advance_scale;
    logic [POS_W-1:0]   wrap_width;
  } cfg_regs_t;

  // One accepted item after the glyph table lookup.
  typedef struct packed {
    mode_e                   mode;
    logic [7:0]              data_byte;
    logic signed [POS_W-1:0] origin_x;
    logic signed [POS_W-1:0] origin_y;
    logic [COLOR_W-1:0]      text_color;
    logic [ADV_W-1:0]        advance;
    logic                    present;
  } item_t;

  // Unsigned saturation of a 25-bit sum to 24 bits.
  function automatic logic [POS_W-1:0] usat24(input logic [POS_W:0] v);
    return v[POS_W] ? UMAX24 : v[POS_W-1:0];
  endfunction

  // Signed saturation of a 26-bit sum to 24 bits.
  function automatic logic signed [POS_W-1:0] ssat24(input logic signed [POS_W+1:0] v);
    logic signed [POS_W+1:0] hi;
    logic signed [POS_W+1:0] lo;
    hi = {{2{SMAX24[POS_W-1]}}, SMAX24};
    lo = {{2{SMIN24[POS_W-1]}}, SMIN24};
    if (v > hi) return SMAX24;
    if (v < lo) return SMIN24;
    return v[POS_W-1:0];
  endfunction

endpackage

[rtl/core/gll_in_if.sv]
// Input channel of the glyph line layout core: valid, ready and one item.
// Depends on gll_pkg for field widths.
interface gll_in_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       mode;
  logic [7:0]                       data_byte;
  logic signed [gll_pkg::POS_W-1:0] origin_x;
  logic signed [gll_pkg::POS_W-1:0] origin_y;
  logic [gll_pkg::COLOR_W-1:0]      text_color;
  logic [6:0]                       glyph_index;
  logic [gll_pkg::ADV_W-1:0]        glyph_advance;
  logic                             glyph_present;

  modport source (output valid, mode, data_byte, origin_x, origin_y, text_color,
                  glyph_index, glyph_advance, glyph_present, input ready);
  modport sink (input valid, mode, data_byte, origin_x, origin_y, text_color,
                glyph_index, glyph_advance, glyph_present, output ready);
endinterface

[rtl/core/gll_out_if.sv]
// Result channel of the glyph line layout core: valid, ready and one result.
// Depends on gll_pkg for field widths.
interface gll_out_if;
  logic                             valid;
  logic                             ready;
  logic                             placed;
  logic signed [gll_pkg::POS_W-1:0] pos_x;
  logic signed [gll_pkg::POS_W-1:0] pos_y;
  logic [gll_pkg::CP_W-1:0]         codepoint;
  logic [gll_pkg::COLOR_W-1:0]      glyph_color;
  logic [gll_pkg::POS_W-1:0]        extent_width;
  logic [gll_pkg::POS_W-1:0]        extent_height;

  modport source (output valid, placed, pos_x, pos_y, codepoint, glyph_color,
                  extent_width, extent_height, input ready);
  modport sink (input valid, placed, pos_x, pos_y, codepoint, glyph_color,
                extent_width, extent_height, output ready);
endinterface

[rtl/core/gll_cfg_if.sv]
// Configuration write channel of the glyph line layout core.
// Depends on gll_pkg for the index width.
interface gll_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [gll_pkg::CFG_IDX_W-1:0]  index;
  logic [31:0]                    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/gll_glyph_store.sv]
// Input register stage with the glyph advance memory and the present bits.
// Depends on gll_pkg and gll_in_if.
module gll_glyph_store #(
  parameter int unsigned GLYPH_SLOTS = gll_pkg::GLYPH_SLOTS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  gll_in_if.sink           in_bus,
  input  logic             s1_take,
  output logic             s1_valid,
  output gll_pkg::item_t   s1_item
);

  localparam int unsigned IDX_W = $clog2(GLYPH_SLOTS);

  logic [gll_pkg::ADV_W-1:0] adv_mem [GLYPH_SLOTS];
  logic [GLYPH_SLOTS-1:0]    present_r;
  logic [GLYPH_SLOTS-1:0]    present_nxt;
  logic                      s1_valid_r;
  logic                      s1_valid_nxt;
  gll_pkg::item_t            item_r;
  logic                      accept;
  logic                      wr_en;
  logic                      rd_in_range;
  logic [IDX_W-1:0]          wr_idx;
  logic [IDX_W-1:0]          rd_idx;
  logic [gll_pkg::CP_W-1:0]  rd_cp;

  // The stage takes a new transaction when it is empty or being drained.
  assign in_bus.ready = !s1_valid_r || s1_take;
  assign accept       = in_bus.valid && in_bus.ready;

  // Table addresses: loads use the given index, text bytes their codepoint less CP_FIRST.
  assign wr_idx      = IDX_W'(in_bus.glyph_index);
  assign wr_en       = accept && (in_bus.mode == gll_pkg::MODE_LOAD) &&
                       (32'(in_bus.glyph_index) < GLYPH_SLOTS);
  assign rd_cp       = in_bus.data_byte[7] ? gll_pkg::CP_QUESTION : in_bus.data_byte[6:0];
  assign rd_idx      = IDX_W'(rd_cp - gll_pkg::CP_FIRST);
  assign rd_in_range = 32'(rd_idx) < GLYPH_SLOTS;

  // Present bits are cleared by reset.
  always_comb begin
    present_nxt = present_r;
    if (wr_en) begin
      present_nxt[wr_idx] = in_bus.glyph_present;
    end
  end

  // Stage occupancy.
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_take) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r  <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      present_r  <= present_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // Advance memory with one write port and one registered read port, and the
  // item payload with the present bit looked up for it.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      adv_mem[wr_idx] <= in_bus.glyph_advance;
    end
    if (accept) begin
      item_r.mode       <= gll_pkg::mode_e'(in_bus.mode);
      item_r.data_byte  <= in_bus.data_byte;
      item_r.origin_x   <= in_bus.origin_x;
      item_r.origin_y   <= in_bus.origin_y;
      item_r.text_color <= in_bus.text_color;
      item_r.present    <= rd_in_range ? present_r[rd_idx] : 1'b0;
      if (rd_in_range) begin
        item_r.advance <= adv_mem[rd_idx];
      end
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_item  = item_r;

endmodule

[rtl/core/gll_layout_step.sv]
// Layout state, per-byte decode, wrap and placement, and the result register.
// Depends on gll_pkg and gll_out_if.
module gll_layout_step (
  input  logic               clk,
  input  logic               rst_n,
  input  gll_pkg::cfg_regs_t cfg,
  input  logic               s1_valid,
  input  gll_pkg::item_t     s1_item,
  output logic               s1_take,
  gll_out_if.source          out_bus
);

  localparam int unsigned W = gll_pkg::POS_W;

  // Layout state.
  logic signed [W-1:0]  start_x_r, start_x_nxt;
  logic signed [W-1:0]  start_y_r, start_y_nxt;
  logic [W-1:0]         line_width_r, line_width_nxt;
  logic [W-1:0]         widest_r, widest_nxt;
  logic [W-1:0]         line_off_r, line_off_nxt;
  logic                 skip_r, skip_nxt;
  logic [gll_pkg::COLOR_W-1:0] color_r, color_nxt;

  // Result register.
  logic                 out_valid_r, out_valid_nxt;
  logic                 placed_r;
  logic signed [W-1:0]  pos_x_r, pos_y_r;
  logic [gll_pkg::CP_W-1:0] cp_r;
  logic [gll_pkg::COLOR_W-1:0] ocolor_r;
  logic [W-1:0]         ext_w_r, ext_h_r;

  // Datapath.
  logic                 out_free;
  logic                 produce;
  logic [gll_pkg::CP_W-1:0] cp_dec;
  logic                 is_cont;
  logic                 glyph_ok;
  logic                 wrap_hit;
  logic                 close_line;
  logic                 place;
  logic [gll_pkg::ADV_W+gll_pkg::SCALE_W-1:0] product;
  logic [gll_pkg::SADV_W-1:0] adv;
  logic [gll_pkg::SIZE_W:0]   step;
  logic [W-1:0]         lw_eff, off_eff, widest_eff, lw_new;
  logic signed [W-1:0]  px, py;
  logic [W-1:0]         ext_w, ext_h;

  assign out_free = !out_valid_r || out_bus.ready;
  assign s1_take  = s1_valid && ((s1_item.mode != gll_pkg::MODE_TEXT) || out_free);
  assign produce  = s1_take && (s1_item.mode == gll_pkg::MODE_TEXT);

  // Byte decode: non-ASCII bytes become a question mark.
  assign cp_dec   = s1_item.data_byte[7] ? gll_pkg::CP_QUESTION : s1_item.data_byte[6:0];
  assign is_cont  = skip_r && (s1_item.data_byte[7:6] == 2'b10);
  assign glyph_ok = cfg.font_is_sans && (cp_dec >= gll_pkg::CP_FIRST) &&
                    (cp_dec <= gll_pkg::CP_LAST) && s1_item.present;

  // Scaled advance, truncated to Q.6.
  assign product = s1_item.advance * cfg.advance_scale;
  assign adv     = product[gll_pkg::ADV_W+gll_pkg::SCALE_W-1:gll_pkg::ADV_SHIFT];
  assign step    = {1'b0, cfg.text_size} + {3'b000, cfg.text_size[gll_pkg::SIZE_W-1:2]};

  // Greedy wrap: the glyph would pass the wrap width on a non-empty line.
  assign wrap_hit = (cfg.wrap_width != '0) && (line_width_r != '0) &&
                    (({1'b0, line_width_r} + (W+1)'(adv)) > {1'b0, cfg.wrap_width});
  assign close_line = !is_cont && ((cp_dec == gll_pkg::CP_NEWLINE) || (glyph_ok && wrap_hit));
  assign place      = !is_cont && (cp_dec != gll_pkg::CP_NEWLINE) && glyph_ok;

  // Line state after an optional line close, then after placement.
  always_comb begin
    lw_eff     = line_width_r;
    off_eff    = line_off_r;
    widest_eff = widest_r;
    if (close_line) begin
      widest_eff = (line_width_r > widest_r) ? line_width_r : widest_r;
      lw_eff     = '0;
      off_eff    = gll_pkg::usat24({1'b0, line_off_r} + (W+1)'(step));
    end
    lw_new = place ? gll_pkg::usat24({1'b0, lw_eff} + (W+1)'(adv)) : lw_eff;
  end

  // Pen position and extents for the result.
  assign px    = gll_pkg::ssat24({{2{start_x_r[W-1]}}, start_x_r} + {2'b00, lw_eff});
  assign py    = gll_pkg::ssat24({{2{start_y_r[W-1]}}, start_y_r} + {2'b00, off_eff});
  assign ext_w = (lw_new > widest_eff) ? lw_new : widest_eff;
  assign ext_h = gll_pkg::usat24((W+1)'(cfg.text_size) + {1'b0, off_eff});

  // State update for the transaction leaving the input stage.
  always_comb begin
    start_x_nxt    = start_x_r;
    start_y_nxt    = start_y_r;
    line_width_nxt = line_width_r;
    widest_nxt     = widest_r;
    line_off_nxt   = line_off_r;
    skip_nxt       = skip_r;
    color_nxt      = color_r;
    if (s1_take) begin
      unique case (s1_item.mode)
        gll_pkg::MODE_START: begin
          start_x_nxt    = s1_item.origin_x;
          start_y_nxt    = s1_item.origin_y;
          color_nxt      = s1_item.text_color;
          line_width_nxt = '0;
          widest_nxt     = '0;
          line_off_nxt   = '0;
          skip_nxt       = 1'b0;
        end
        gll_pkg::MODE_TEXT: begin
          if (!is_cont) begin
            skip_nxt = s1_item.data_byte[7];
          end
          line_width_nxt = lw_new;
          widest_nxt     = widest_eff;
          line_off_nxt   = off_eff;
        end
        gll_pkg::MODE_LOAD, gll_pkg::MODE_NONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  // Result register occupancy.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (produce) begin
      out_valid_nxt = 1'b1;
    end else if (out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_x_r    <= '0;
      start_y_r    <= '0;
      line_width_r <= '0;
      widest_r     <= '0;
      line_off_r   <= '0;
      skip_r       <= 1'b0;
      color_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      start_x_r    <= start_x_nxt;
      start_y_r    <= start_y_nxt;
      line_width_r <= line_width_nxt;
      widest_r     <= widest_nxt;
      line_off_r   <= line_off_nxt;
      skip_r       <= skip_nxt;
      color_r      <= color_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (produce) begin
      placed_r <= place;
      pos_x_r  <= place ? px : '0;
      pos_y_r  <= place ? py : '0;
      cp_r     <= place ? cp_dec : '0;
      ocolor_r <= color_r;
      ext_w_r  <= ext_w;
      ext_h_r  <= ext_h;
    end
  end

  assign out_bus.valid         = out_valid_r;
  assign out_bus.placed        = placed_r;
  assign out_bus.pos_x         = pos_x_r;
  assign out_bus.pos_y         = pos_y_r;
  assign out_bus.codepoint     = cp_r;
  assign out_bus.glyph_color   = ocolor_r;
  assign out_bus.extent_width  = ext_w_r;
  assign out_bus.extent_height = ext_h_r;

endmodule

[rtl/core/glyph_line_layout_core.sv]
// Top level of the glyph line layout core: configuration registers and stages.
// Depends on gll_pkg, the three channel interfaces, gll_glyph_store, gll_layout_step.
//
//   channel   direction  carries
//   in_bus    sink       start, text byte or glyph table load
//   out_bus   source     one result per text byte
//   cfg_bus   sink       register index and write data
//
// Two register stages: the input stage holds an item with its table lookup,
// then one pass of logic updates the layout state and fills the result register.
// One item per cycle, but a text byte waits in the input stage while the result is stalled.
// Start and load items give no result and never wait on the result channel.
// Reset is synchronous, active low; the present bits clear at once with it.
module glyph_line_layout_core #(
  parameter int unsigned GLYPH_SLOTS = gll_pkg::GLYPH_SLOTS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  gll_in_if.sink    in_bus,
  gll_out_if.source out_bus,
  gll_cfg_if.sink   cfg_bus
);

  gll_pkg::cfg_regs_t cfg_r, cfg_nxt;
  logic               s1_valid;
  logic               s1_take;
  gll_pkg::item_t     s1_item;

  // Configuration writes are always taken.
  assign cfg_bus.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_bus.valid) begin
      unique case (gll_pkg::cfg_reg_e'(cfg_bus.index))
        gll_pkg::CFG_FONT_IS_SANS:  cfg_nxt.font_is_sans  = cfg_bus.data[0];
        gll_pkg::CFG_TEXT_SIZE:     cfg_nxt.text_size     = cfg_bus.data[15:0];
        gll_pkg::CFG_ADVANCE_SCALE: cfg_nxt.advance_scale = cfg_bus.data[15:0];
        gll_pkg::CFG_WRAP_WIDTH:    cfg_nxt.wrap_width    = cfg_bus.data[23:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.font_is_sans  <= 1'b1;
      cfg_r.text_size     <= 16'd1024;
      cfg_r.advance_scale <= 16'd4096;
      cfg_r.wrap_width    <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  gll_glyph_store #(
    .GLYPH_SLOTS (GLYPH_SLOTS)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_bus   (in_bus),
    .s1_take  (s1_take),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  gll_layout_step u_step (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .s1_valid (s1_valid),
    .s1_item  (s1_item),
    .s1_take  (s1_take),
    .out_bus  (out_bus)
  );

  // A result without a placed glyph carries no position and no codepoint.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid && !out_bus.placed |->
      out_bus.codepoint == '0 && out_bus.pos_x == '0 && out_bus.pos_y == '0)
    else $error("unplaced result carries position or codepoint");

  // A placed glyph is always a printable codepoint.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid && out_bus.placed |->
      out_bus.codepoint >= gll_pkg::CP_FIRST && out_bus.codepoint <= gll_pkg::CP_LAST)
    else $error("placed codepoint outside printable range");

  // The input stage is only drained when it holds a transaction.
  assert property (@(posedge clk) disable iff (!rst_n)
    s1_take |-> s1_valid)
    else $error("input stage drained while empty");

  // A text byte leaving the input stage shows up as a result in the following cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    s1_take && s1_item.mode == gll_pkg::MODE_TEXT |=> out_bus.valid)
    else $error("text byte produced no result");

endmodule

[tb/sv/glyph_line_layout_core_test.sv]
// Self-checking testbench for glyph_line_layout_core: directed rows, then random phases.
// Depends on gll_pkg, gll_in_if, gll_out_if, gll_cfg_if and the core itself.
// Expected glyph reports come from a layout predictor kept inside this module.
module glyph_line_layout_core_test;

  localparam int     RANDOM_PER_PHASE = 190;
  localparam int     PHASE_COUNT      = 9;
  localparam int     HOLD_OFF_CYCLES  = 400;
  localparam int     WATCHDOG_LIMIT   = 5000;
  localparam int     REST_CYCLES      = 6;
  localparam longint POS_HI           = 64'sd8388607;
  localparam longint POS_LO           = -64'sd8388608;
  localparam longint COUNT_MAX        = 64'sd16777215;

  // One input transaction, whatever its kind.
  typedef struct {
    gll_pkg::mode_e mode;
    logic [7:0]     data_byte;
    logic [23:0]    origin_x;
    logic [23:0]    origin_y;
    logic [31:0]    text_color;
    logic [6:0]     glyph_index;
    logic [15:0]    glyph_advance;
    logic           glyph_present;
  } layout_item_t;

  // One result transaction.
  typedef struct packed {
    logic        placed;
    logic [23:0] pos_x;
    logic [23:0] pos_y;
    logic [6:0]  codepoint;
    logic [31:0] glyph_color;
    logic [23:0] extent_width;
    logic [23:0] extent_height;
  } glyph_report_t;

  // A stimulus row; typed rows carry a report read straight off the spec.
  typedef struct {
    layout_item_t  item;
    bit            typed;
    glyph_report_t want;
  } stim_row_t;

  logic clk;
  logic rst_n;

  gll_in_if  in_bus ();
  gll_out_if out_bus ();
  gll_cfg_if cfg_bus ();

  glyph_line_layout_core i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  // Predictor state: register mirror, glyph table and layout counters.
  logic               cfg_sans;
  logic [15:0]        cfg_size;
  logic [15:0]        cfg_scale;
  logic [23:0]        cfg_wrap;
  logic [15:0]        adv_mem [0:127];
  logic               have_glyph [0:127];
  logic signed [23:0] org_x;
  logic signed [23:0] org_y;
  logic [23:0]        line_w;
  logic [23:0]        widest_w;
  logic [23:0]        line_off_y;
  logic               skip_cont;
  logic [31:0]        color_q;

  glyph_report_t glyph_reports_due [$];
  int            bad_results;
  int            burst_left;
  int            quiet_cycles;
  bit            hold_off_req;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Closes the current line: widest line, line width and vertical offset.
  function automatic void end_line();
    longint off;
    off = longint'(line_off_y) + longint'(cfg_size) + longint'(cfg_size >> 2);
    if (line_w > widest_w) widest_w = line_w;
    line_w = '0;
    line_off_y = (off > COUNT_MAX) ? 24'hFF_FFFF : off[23:0];
  endfunction

  // Applies one accepted transaction to the layout state and forms its report.
  function automatic void lay_out_item(input layout_item_t it, output bit gives,
                                       output glyph_report_t rep);
    logic [7:0] b;
    logic [6:0] cp;
    longint     adv;
    longint     px;
    longint     py;
    longint     sum;
    longint     sx;
    longint     sy;
    gives = 1'b0;
    rep = '0;
    case (it.mode)
      gll_pkg::MODE_START: begin
        org_x = it.origin_x;
        org_y = it.origin_y;
        color_q = it.text_color;
        line_w = '0;
        widest_w = '0;
        line_off_y = '0;
        skip_cont = 1'b0;
      end
      gll_pkg::MODE_LOAD: begin
        adv_mem[it.glyph_index] = it.glyph_advance;
        have_glyph[it.glyph_index] = it.glyph_present;
      end
      gll_pkg::MODE_TEXT: begin
        b = it.data_byte;
        // A continuation byte (10xxxxxx) after a non-ASCII lead is swallowed.
        if (!(skip_cont && b[7:6] == 2'b10)) begin
          skip_cont = b[7];
          cp = b[7] ? gll_pkg::CP_QUESTION : b[6:0];
          if (cp == gll_pkg::CP_NEWLINE) begin
            end_line();
          end else if (cfg_sans && cp >= gll_pkg::CP_FIRST && cp <= gll_pkg::CP_LAST &&
                       have_glyph[cp - gll_pkg::CP_FIRST]) begin
            adv = (longint'(adv_mem[cp - gll_pkg::CP_FIRST]) * longint'(cfg_scale)) >>
                  gll_pkg::ADV_SHIFT;
            // Greedy wrap before placing, only when the wrap width and line width are nonzero.
            if (cfg_wrap != 0 && line_w != 0 &&
                longint'(line_w) + adv > longint'(cfg_wrap)) begin
              end_line();
            end
            sx = org_x;
            sy = org_y;
            px = sx + longint'(line_w);
            py = sy + longint'(line_off_y);
            if (px > POS_HI) px = POS_HI;
            if (px < POS_LO) px = POS_LO;
            if (py > POS_HI) py = POS_HI;
            if (py < POS_LO) py = POS_LO;
            rep.placed = 1'b1;
            rep.pos_x = px[23:0];
            rep.pos_y = py[23:0];
            rep.codepoint = cp;
            sum = longint'(line_w) + adv;
            line_w = (sum > COUNT_MAX) ? 24'hFF_FFFF : sum[23:0];
          end
        end
        sum = longint'(cfg_size) + longint'(line_off_y);
        rep.glyph_color = color_q;
        rep.extent_width = (line_w > widest_w) ? line_w : widest_w;
        rep.extent_height = (sum > COUNT_MAX) ? 24'hFF_FFFF : sum[23:0];
        gives = 1'b1;
      end
      default: ;
    endcase
  endfunction

  // Row builders; fields that the kind does not use carry random noise.
  function automatic stim_row_t blank_row(input gll_pkg::mode_e m);
    stim_row_t r;
    r.item.mode = m;
    r.item.data_byte = 8'($urandom);
    r.item.origin_x = 24'($urandom);
    r.item.origin_y = 24'($urandom);
    r.item.text_color = $urandom;
    r.item.glyph_index = 7'($urandom);
    r.item.glyph_advance = 16'($urandom);
    r.item.glyph_present = 1'($urandom);
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic stim_row_t text_row(input logic [7:0] b);
    stim_row_t r;
    r = blank_row(gll_pkg::MODE_TEXT);
    r.item.data_byte = b;
    return r;
  endfunction

  function automatic stim_row_t start_row(input logic [23:0] ox, input logic [23:0] oy,
                                          input logic [31:0] color);
    stim_row_t r;
    r = blank_row(gll_pkg::MODE_START);
    r.item.origin_x = ox;
    r.item.origin_y = oy;
    r.item.text_color = color;
    return r;
  endfunction

  function automatic stim_row_t load_row(input logic [6:0] idx, input logic [15:0] adv,
                                         input logic present);
    stim_row_t r;
    r = blank_row(gll_pkg::MODE_LOAD);
    r.item.glyph_index = idx;
    r.item.glyph_advance = adv;
    r.item.glyph_present = present;
    return r;
  endfunction

  function automatic stim_row_t checked_text(input logic [7:0] b, input logic placed,
                                             input logic [23:0] px, input logic [23:0] py,
                                             input logic [6:0] cp, input logic [31:0] color,
                                             input logic [23:0] ew, input logic [23:0] eh);
    stim_row_t r;
    r = text_row(b);
    r.typed = 1'b1;
    r.want = '{placed, px, py, cp, color, ew, eh};
    return r;
  endfunction

  // Random table entry; big entries make long lines that saturate the counters.
  function automatic stim_row_t random_load(input bit big);
    logic [6:0]  idx;
    logic [15:0] adv;
    idx = ($urandom_range(7) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(94));
    if (big) begin
      adv = 16'($urandom_range(16'hFFFF, 16'hC000));
    end else begin
      adv = ($urandom_range(1) == 0) ? 16'($urandom_range(16'h0C00)) : 16'($urandom);
    end
    return load_row(idx, adv, big || ($urandom_range(99) < 85));
  endfunction

  // Origins lean toward both ends of the signed range and toward zero.
  function automatic logic [23:0] pick_origin();
    case ($urandom_range(3))
      0: begin
        return 24'h7F_FFFF - 24'($urandom_range(4096));
      end
      1: begin
        return 24'h80_0000 + 24'($urandom_range(4096));
      end
      2: begin
        return 24'($urandom_range(8191)) - 24'd4096;
      end
      default: begin
        return 24'($urandom);
      end
    endcase
  endfunction

  // Offers one transaction, predicts its report once accepted, then paces the burst.
  task automatic offer(input stim_row_t row);
    glyph_report_t due;
    bit            gives;
    int            gap;
    in_bus.valid <= 1'b1;
    in_bus.mode <= row.item.mode;
    in_bus.data_byte <= row.item.data_byte;
    in_bus.origin_x <= row.item.origin_x;
    in_bus.origin_y <= row.item.origin_y;
    in_bus.text_color <= row.item.text_color;
    in_bus.glyph_index <= row.item.glyph_index;
    in_bus.glyph_advance <= row.item.glyph_advance;
    in_bus.glyph_present <= row.item.glyph_present;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    lay_out_item(row.item, gives, due);
    if (gives) glyph_reports_due.push_back(row.typed ? row.want : due);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(48, 1);
      gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(8, 1);
      if (gap > 0) begin
        in_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Stops offering and waits until every expected report has come back.
  task automatic settle();
    in_bus.valid <= 1'b0;
    while (glyph_reports_due.size() != 0) @(posedge clk);
    repeat (REST_CYCLES) @(posedge clk);
  endtask

  // Writes all four registers, with noise in the unused upper data bits.
  task automatic program_regs(input logic sans, input logic [15:0] size,
                              input logic [15:0] scale, input logic [23:0] wrap);
    gll_pkg::cfg_reg_e reg_idx;
    logic [31:0]       noise;
    logic [31:0]       word;
    for (int r = 0; r < 4; r++) begin
      noise = $urandom;
      case (r)
        0: begin
          reg_idx = gll_pkg::CFG_FONT_IS_SANS;
          word = {noise[31:1], sans};
        end
        1: begin
          reg_idx = gll_pkg::CFG_TEXT_SIZE;
          word = {noise[31:16], size};
        end
        2: begin
          reg_idx = gll_pkg::CFG_ADVANCE_SCALE;
          word = {noise[31:16], scale};
        end
        default: begin
          reg_idx = gll_pkg::CFG_WRAP_WIDTH;
          word = {noise[31:24], wrap};
        end
      endcase
      cfg_bus.valid <= 1'b1;
      cfg_bus.index <= reg_idx;
      cfg_bus.data <= word;
      @(posedge clk);
      while (!cfg_bus.ready) @(posedge clk);
    end
    cfg_bus.valid <= 1'b0;
    cfg_sans = sans;
    cfg_size = size;
    cfg_scale = scale;
    cfg_wrap = wrap;
  endtask

  // Result receiver: stall segments of random density, plus one long hold-off.
  initial begin : receiver
    int seg_left;
    int stall_pct;
    out_bus.ready <= 1'b0;
    seg_left = 0;
    stall_pct = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_bus.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(60, 1);
          case ($urandom_range(4))
            0, 1: stall_pct = 0;
            2: stall_pct = 30;
            3: stall_pct = 60;
            default: stall_pct = 90;
          endcase
        end
        seg_left--;
        out_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Compares one field and reports a mismatch.
  function automatic bit field_ok(input string name, input logic [31:0] want,
                                  input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // Result checker: each accepted report against the oldest expectation.
  always @(posedge clk) begin : result_check
    glyph_report_t seen;
    glyph_report_t want;
    bit            ok;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      seen.placed = out_bus.placed;
      seen.pos_x = out_bus.pos_x;
      seen.pos_y = out_bus.pos_y;
      seen.codepoint = out_bus.codepoint;
      seen.glyph_color = out_bus.glyph_color;
      seen.extent_width = out_bus.extent_width;
      seen.extent_height = out_bus.extent_height;
      if (glyph_reports_due.size() == 0) begin
        $display("%0t: unexpected report, expected none, actual %h", $time, seen);
        bad_results++;
      end else begin
        want = glyph_reports_due.pop_front();
        ok = field_ok("placed", 32'(want.placed), 32'(seen.placed));
        ok &= field_ok("pos_x", 32'(want.pos_x), 32'(seen.pos_x));
        ok &= field_ok("pos_y", 32'(want.pos_y), 32'(seen.pos_y));
        ok &= field_ok("codepoint", 32'(want.codepoint), 32'(seen.codepoint));
        ok &= field_ok("glyph_color", want.glyph_color, seen.glyph_color);
        ok &= field_ok("extent_width", 32'(want.extent_width), 32'(seen.extent_width));
        ok &= field_ok("extent_height", 32'(want.extent_height), 32'(seen.extent_height));
        if (!ok) bad_results++;
      end
    end
  end

  // Watchdog: ends the run when no transaction moves on any channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("glyph_line_layout_core_test: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Main sequence: reset, directed rows, then random phases over several settings.
  initial begin : stimulus
    stim_row_t   opening_rows [$];
    stim_row_t   row;
    logic        sans;
    logic [15:0] size;
    logic [15:0] scale;
    logic [23:0] wrap;
    int          start_pct;
    int          nl_pct;
    bit          big_table;
    bit          opening_start;
    int          pick;
    logic [7:0]  b;

    // Reset values of the predictor state.
    cfg_sans = 1'b1;
    cfg_size = 16'd1024;
    cfg_scale = 16'd4096;
    cfg_wrap = '0;
    for (int i = 0; i < 128; i++) begin
      adv_mem[i] = '0;
      have_glyph[i] = 1'b0;
    end
    org_x = '0;
    org_y = '0;
    line_w = '0;
    widest_w = '0;
    line_off_y = '0;
    skip_cont = 1'b0;
    color_q = '0;
    bad_results = 0;
    burst_left = 0;
    hold_off_req = 1'b0;

    rst_n <= 1'b0;
    in_bus.valid <= 1'b0;
    in_bus.mode <= gll_pkg::MODE_NONE;
    in_bus.data_byte <= '0;
    in_bus.origin_x <= '0;
    in_bus.origin_y <= '0;
    in_bus.text_color <= '0;
    in_bus.glyph_index <= '0;
    in_bus.glyph_advance <= '0;
    in_bus.glyph_present <= 1'b0;
    cfg_bus.valid <= 1'b0;
    cfg_bus.index <= gll_pkg::CFG_FONT_IS_SANS;
    cfg_bus.data <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows under reset settings: empty table, newline, saturated pen x,
    // zero-width glyphs, non-ASCII leads with their continuations, control bytes,
    // an unused mode and an absent glyph.
    opening_rows.push_back(checked_text(8'h41, 1'b0, 24'd0, 24'd0, 7'd0, 32'h0,
                                        24'd0, 24'd1024));
    opening_rows.push_back(checked_text(8'h0A, 1'b0, 24'd0, 24'd0, 7'd0, 32'h0,
                                        24'd0, 24'd2304));
    opening_rows.push_back(start_row(24'h7F_FFFF, 24'h80_0000, 32'hFFFF_FFFF));
    opening_rows.push_back(load_row(7'd33, 16'hFFFF, 1'b1));
    opening_rows.push_back(checked_text(8'h41, 1'b1, 24'h7F_FFFF, 24'h80_0000, 7'h41,
                                        32'hFFFF_FFFF, 24'd16383, 24'd1024));
    opening_rows.push_back(checked_text(8'h41, 1'b1, 24'h7F_FFFF, 24'h80_0000, 7'h41,
                                        32'hFFFF_FFFF, 24'd32766, 24'd1024));
    opening_rows.push_back(load_row(7'd0, 16'h0000, 1'b1));
    opening_rows.push_back(load_row(7'd94, 16'h0100, 1'b1));
    opening_rows.push_back(load_row(7'd127, 16'hFFFF, 1'b1));
    opening_rows.push_back(load_row(7'd31, 16'h0400, 1'b1));
    opening_rows.push_back(start_row(24'd0, 24'd0, 32'h1234_5678));
    opening_rows.push_back(checked_text(8'h20, 1'b1, 24'd0, 24'd0, 7'h20, 32'h1234_5678,
                                        24'd0, 24'd1024));
    opening_rows.push_back(checked_text(8'h7E, 1'b1, 24'd0, 24'd0, 7'h7E, 32'h1234_5678,
                                        24'd64, 24'd1024));
    opening_rows.push_back(checked_text(8'hC3, 1'b1, 24'd64, 24'd0, 7'h3F, 32'h1234_5678,
                                        24'd320, 24'd1024));
    opening_rows.push_back(checked_text(8'hA9, 1'b0, 24'd0, 24'd0, 7'd0, 32'h1234_5678,
                                        24'd320, 24'd1024));
    opening_rows.push_back(checked_text(8'h80, 1'b0, 24'd0, 24'd0, 7'd0, 32'h1234_5678,
                                        24'd320, 24'd1024));
    opening_rows.push_back(checked_text(8'hFF, 1'b1, 24'd320, 24'd0, 7'h3F, 32'h1234_5678,
                                        24'd576, 24'd1024));
    opening_rows.push_back(checked_text(8'h41, 1'b1, 24'd576, 24'd0, 7'h41, 32'h1234_5678,
                                        24'd16959, 24'd1024));
    opening_rows.push_back(checked_text(8'h00, 1'b0, 24'd0, 24'd0, 7'd0, 32'h1234_5678,
                                        24'd16959, 24'd1024));
    opening_rows.push_back(checked_text(8'h7F, 1'b0, 24'd0, 24'd0, 7'd0, 32'h1234_5678,
                                        24'd16959, 24'd1024));
    opening_rows.push_back(checked_text(8'h1F, 1'b0, 24'd0, 24'd0, 7'd0, 32'h1234_5678,
                                        24'd16959, 24'd1024));
    opening_rows.push_back(checked_text(8'h0A, 1'b0, 24'd0, 24'd0, 7'd0, 32'h1234_5678,
                                        24'd16959, 24'd2304));
    opening_rows.push_back(checked_text(8'h7E, 1'b1, 24'd0, 24'd1280, 7'h7E, 32'h1234_5678,
                                        24'd16959, 24'd2304));
    opening_rows.push_back(blank_row(gll_pkg::MODE_NONE));
    opening_rows.push_back(checked_text(8'h42, 1'b0, 24'd0, 24'd0, 7'd0, 32'h1234_5678,
                                        24'd16959, 24'd2304));
    foreach (opening_rows[i]) offer(opening_rows[i]);

    // Random phases, each under its own register settings.
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      opening_start = 1'b1;
      start_pct = 3;
      nl_pct = 8;
      big_table = 1'b0;
      sans = 1'b1;
      case (ph)
        0: begin
          size = 16'd1024;
          scale = 16'd4096;
          wrap = '0;
        end
        1: begin
          size = 16'd1024;
          scale = 16'd4096;
          wrap = 24'd3000;
        end
        2: begin
          sans = 1'b0;
          size = 16'($urandom);
          scale = 16'($urandom);
          wrap = 24'($urandom);
        end
        3: begin
          size = 16'd0;
          scale = 16'd0;
          wrap = 24'd1;
        end
        4: begin
          // Tall text: the vertical offset and height run into saturation.
          size = 16'hFFFF;
          scale = 16'hFFFF;
          wrap = 24'hFF_FFFF;
          start_pct = 0;
          nl_pct = 60;
        end
        5: begin
          size = 16'hFFFF;
          scale = 16'hFFFF;
          wrap = '0;
          opening_start = 1'b0;
          start_pct = 0;
          nl_pct = 60;
        end
        6: begin
          // One long line of wide glyphs: line width and pen x saturate.
          size = 16'hFFFF;
          scale = 16'hFFFF;
          wrap = '0;
          start_pct = 0;
          nl_pct = 0;
          big_table = 1'b1;
        end
        7: begin
          size = 16'($urandom);
          scale = 16'($urandom);
          wrap = 24'($urandom_range(16'h3FFF, 1));
        end
        default: begin
          size = 16'd16;
          scale = 16'd2048;
          wrap = 24'd1;
        end
      endcase
      settle();
      program_regs(sans, size, scale, wrap);

      // Opening: a start unless the phase skips it, and a fresh set of table entries.
      if (opening_start) begin
        offer(start_row(pick_origin(),
                        (ph == 4) ? (24'h7F_0000 | 24'($urandom_range(16'hFFFF))) :
                                    pick_origin(),
                        $urandom));
      end
      if (big_table) begin
        for (int i = 0; i <= int'(gll_pkg::CP_LAST - gll_pkg::CP_FIRST); i++) begin
          offer(load_row(7'(i), 16'($urandom_range(16'hFFFF, 16'hC000)), 1'b1));
        end
      end else begin
        repeat (12) offer(random_load(1'b0));
      end

      if (ph == 1) hold_off_req = 1'b1;

      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        pick = $urandom_range(99);
        if (pick < start_pct) begin
          row = start_row(pick_origin(), pick_origin(), $urandom);
        end else if (pick < start_pct + 12) begin
          row = random_load(big_table);
        end else if (pick < start_pct + 14) begin
          row = blank_row(gll_pkg::MODE_NONE);
        end else begin
          pick = $urandom_range(99);
          if (pick < nl_pct) begin
            b = {1'b0, gll_pkg::CP_NEWLINE};
          end else begin
            pick = $urandom_range(99);
            if (pick < 62) b = 8'($urandom_range(gll_pkg::CP_LAST, gll_pkg::CP_FIRST));
            else if (pick < 74) b = 8'($urandom_range(8'hFF, 8'hC0));
            else if (pick < 88) b = 8'($urandom_range(8'hBF, 8'h80));
            else b = 8'($urandom_range(255));
          end
          row = text_row(b);
        end
        offer(row);
      end
    end

    settle();
    if (bad_results == 0) begin
      $display("glyph_line_layout_core_test: done, clean");
    end else begin
      $display("glyph_line_layout_core_test: done, errors");
    end
    $finish;
  end

endmodule
